// ----- rtl/scsa_pkg.sv -----
// Package for the size-class slab allocator: codes, widths and the class size table.
// It has no dependencies. Every file of the block uses it.
`default_nettype none

package scsa_pkg;

	localparam int NUM_CLASSES     = 12;
	localparam int PAGE_BYTES      = 4096;
	localparam int HEADER_BYTES    = 8;
	localparam int ARENA_PAGES_DEF = 16;

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int OFF_W      = PAGE_SHIFT + 1;
	localparam int SIZE_W     = 12;
	localparam int ADDR_W     = 16;
	localparam int BYTES_W    = 24;
	localparam int CLASS_W    = 4;
	localparam int LINK_DEPTH = 8192;
	localparam int LINK_W     = $clog2(LINK_DEPTH);
	localparam int SLOT_SHIFT = 3;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_OVERSIZE = 2'd1;
	localparam logic [1:0] ST_NO_PAGE  = 2'd2;
	localparam logic [1:0] ST_NULL     = 2'd3;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [OFF_W-1:0]  off_t;

	function automatic logic [SIZE_W-1:0] class_bytes(input logic [CLASS_W-1:0] idx);
		logic [SIZE_W-1:0] sz;
		unique case (idx)
			4'd0: sz = 12'd8;
			4'd1: sz = 12'd16;
			4'd2: sz = 12'd24;
			4'd3: sz = 12'd32;
			4'd4: sz = 12'd48;
			4'd5: sz = 12'd64;
			4'd6: sz = 12'd96;
			4'd7: sz = 12'd128;
			4'd8: sz = 12'd256;
			4'd9: sz = 12'd512;
			4'd10: sz = 12'd1024;
			4'd11: sz = 12'd2048;
			default: sz = 12'd8;
		endcase
		return sz;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/size_class_slab_allocator_core.sv -----
// Size-class slab allocator: class state in registers, slot links in a synchronous memory.
// Depends on scsa_pkg.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_ready  opcode, request_bytes, block_address,
//                                            address_is_null
//   out      from block out_valid / out_ready status, granted_address, class_index
//
// On acceptance the block picks the class and reads the link memory at that class's list
// head into the second stage, which then applies the update and loads the result register.
// A new request is taken only once the second stage has passed the previous one on.
// Reset clears all lists, pages and handshake state; the link memory needs no clearing.
// A stalled result holds the second stage, and in_ready stays low until it moves on.
`default_nettype none

module size_class_slab_allocator_core #(
	parameter int ARENA_PAGES = scsa_pkg::ARENA_PAGES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     opcode,
	input  wire logic [scsa_pkg::BYTES_W-1:0]   request_bytes,
	input  wire logic [scsa_pkg::ADDR_W-1:0]    block_address,
	input  wire logic                           address_is_null,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          status,
	output logic [scsa_pkg::ADDR_W-1:0]         granted_address,
	output logic [scsa_pkg::CLASS_W-1:0]        class_index
);

	localparam int PAGE_W = $clog2(ARENA_PAGES + 1);
	localparam int GRANT_W = PAGE_W + scsa_pkg::PAGE_SHIFT;
	localparam int NC = scsa_pkg::NUM_CLASSES;

	// Per-class state.
	logic [NC-1:0]        has_page_q;
	logic [NC-1:0]        nonempty_q;
	scsa_pkg::addr_t      head_q [NC];
	logic [PAGE_W-1:0]    page_q [NC];
	scsa_pkg::off_t       off_q  [NC];
	logic [PAGE_W-1:0]    next_page_q;

	// Slot link memory: {nonempty, next head}.
	logic [scsa_pkg::ADDR_W:0] link_mem [scsa_pkg::LINK_DEPTH];
	logic [scsa_pkg::ADDR_W:0] link_rd_s1;

	// Second stage.
	logic                            valid_s1;
	logic [1:0]                      op_s1;
	logic [scsa_pkg::CLASS_W-1:0]    class_s1;
	logic                            oversize_s1;
	logic                            null_s1;
	scsa_pkg::addr_t                 addr_s1;

	// Result register.
	logic                            out_valid_q;
	logic [1:0]                      status_q;
	scsa_pkg::addr_t                 granted_q;
	logic [scsa_pkg::CLASS_W-1:0]    class_q;

	logic                            accept;
	logic                            fire_s1;
	logic [scsa_pkg::CLASS_W-1:0]    pick_class;
	logic                            pick_oversize;

	logic [1:0]                      res_status;
	scsa_pkg::addr_t                 res_granted;
	logic [scsa_pkg::CLASS_W-1:0]    res_class;
	logic                            do_clear;
	logic                            do_pop;
	logic                            do_push;
	logic                            do_bump;
	logic                            need_page;
	logic [scsa_pkg::SIZE_W-1:0]     size_s1;
	scsa_pkg::off_t                  off_sum;
	logic [GRANT_W-1:0]              grant_full;
	logic [PAGE_W-1:0]               grant_page;
	logic [scsa_pkg::PAGE_SHIFT-1:0] grant_off;

	assign accept   = in_valid && in_ready;
	assign in_ready = !valid_s1;
	assign fire_s1  = valid_s1 && (!out_valid_q || out_ready);

	always_comb begin
		pick_class = '0;
		pick_oversize = 1'b1;
		for (int c = NC - 1; c >= 0; c--) begin
			if (request_bytes
				<= scsa_pkg::BYTES_W'(scsa_pkg::class_bytes(scsa_pkg::CLASS_W'(c)))) begin
				pick_class = scsa_pkg::CLASS_W'(c);
				pick_oversize = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			link_mem[addr_s1[scsa_pkg::SLOT_SHIFT +: scsa_pkg::LINK_W]] <=
				{nonempty_q[class_s1], head_q[class_s1]};
		if (accept)
			link_rd_s1 <= link_mem[head_q[pick_class][scsa_pkg::SLOT_SHIFT +: scsa_pkg::LINK_W]];
	end

	always_comb begin
		size_s1 = scsa_pkg::class_bytes(class_s1);
		off_sum = off_q[class_s1] + scsa_pkg::OFF_W'(size_s1);
		need_page = !has_page_q[class_s1] || (off_sum > scsa_pkg::OFF_W'(scsa_pkg::PAGE_BYTES));
		grant_page = need_page ? next_page_q : page_q[class_s1];
		grant_off = need_page ? scsa_pkg::PAGE_SHIFT'(scsa_pkg::HEADER_BYTES)
			: off_q[class_s1][scsa_pkg::PAGE_SHIFT-1:0];
		grant_full = {grant_page, grant_off};
		res_status = scsa_pkg::ST_DONE;
		res_granted = '0;
		res_class = class_s1;
		do_clear = 1'b0;
		do_pop = 1'b0;
		do_push = 1'b0;
		do_bump = 1'b0;
		case (op_s1)
			scsa_pkg::OP_ALLOC: begin
				if (oversize_s1) begin
					res_status = scsa_pkg::ST_OVERSIZE;
				end else if (nonempty_q[class_s1]) begin
					res_granted = head_q[class_s1];
					do_pop = fire_s1;
				end else if (need_page && next_page_q == PAGE_W'(ARENA_PAGES)) begin
					res_status = scsa_pkg::ST_NO_PAGE;
				end else begin
					res_granted = scsa_pkg::ADDR_W'(grant_full);
					do_bump = fire_s1;
				end
			end
			scsa_pkg::OP_FREE: begin
				if (null_s1)
					res_status = scsa_pkg::ST_NULL;
				else if (oversize_s1)
					res_status = scsa_pkg::ST_OVERSIZE;
				else
					do_push = fire_s1;
			end
			scsa_pkg::OP_CLEAR: begin
				res_class = '0;
				do_clear = fire_s1;
			end
			default: begin
				res_class = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			has_page_q <= '0;
			nonempty_q <= '0;
			next_page_q <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (fire_s1)
				valid_s1 <= 1'b0;
			if (fire_s1)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (do_clear) begin
				has_page_q <= '0;
				nonempty_q <= '0;
				next_page_q <= '0;
			end
			if (do_pop)
				nonempty_q[class_s1] <= link_rd_s1[scsa_pkg::ADDR_W];
			if (do_push)
				nonempty_q[class_s1] <= 1'b1;
			if (do_bump && need_page) begin
				has_page_q[class_s1] <= 1'b1;
				next_page_q <= next_page_q + PAGE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= opcode;
			class_s1 <= pick_class;
			oversize_s1 <= pick_oversize;
			null_s1 <= address_is_null;
			addr_s1 <= block_address;
		end
		if (fire_s1) begin
			status_q <= res_status;
			granted_q <= res_granted;
			class_q <= res_class;
		end
		if (do_pop)
			head_q[class_s1] <= link_rd_s1[scsa_pkg::ADDR_W-1:0];
		if (do_push)
			head_q[class_s1] <= addr_s1;
		if (do_bump) begin
			if (need_page) begin
				page_q[class_s1] <= next_page_q;
				off_q[class_s1] <= scsa_pkg::OFF_W'(scsa_pkg::HEADER_BYTES)
					+ scsa_pkg::OFF_W'(size_s1);
			end else begin
				off_q[class_s1] <= off_sum;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign granted_address = granted_q;
	assign class_index = class_q;

	a_page_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_page_q <= PAGE_W'(ARENA_PAGES))
		else $error("page counter passed the arena size");

	a_no_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == scsa_pkg::ST_NO_PAGE |-> granted_q == '0)
		else $error("failed allocation carries an address");

	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> !valid_s1 && out_valid_q)
		else $error("second stage did not finish into an empty result register");

	a_push_sets: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> nonempty_q[$past(class_s1)])
		else $error("free did not mark its list nonempty");

endmodule

`default_nettype wire
